### rtl/brim_pkg.sv
// Package for the bip-buffer index manager: widths, codes, shared structs.
`default_nettype none
package brim_pkg;

    localparam int unsigned IDX_W   = 16;
    localparam int unsigned SIZE_W  = 17;
    localparam int unsigned CALC_W  = 18;

    localparam logic [32:0] MAX_SIZE     = 33'd65536;
    localparam logic [32:0] INDEX_SPAN   = 33'd65536;
    localparam logic [SIZE_W-1:0] SIZE_CAP = (MAX_SIZE > INDEX_SPAN)
                                             ? INDEX_SPAN[SIZE_W-1:0]
                                             : MAX_SIZE[SIZE_W-1:0];
    localparam logic [SIZE_W-1:0] SIZE_MIN   = 17'd2;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 17'd65536;

    typedef enum logic [1:0] {
        MODE_WR_ACQ = 2'd0,
        MODE_WR_REL = 2'd1,
        MODE_RD_ACQ = 2'd2,
        MODE_RD_REL = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NOSPACE = 2'd1,
        STAT_TOOBIG  = 2'd2
    } t_status;

    localparam logic [2:0] REG_BUFFER_SIZE = 3'd0;

    typedef struct packed {
        logic              clear;
        logic [SIZE_W-1:0] size;
    } t_cfg;

    typedef struct packed {
        t_status           status;
        logic [IDX_W-1:0]  offset;
        logic [SIZE_W-1:0] avail;
    } t_result;

endpackage
`default_nettype wire

### rtl/brim_cfg.sv
// APB register block holding buffer_size and its clamped effective value.
`default_nettype none
module brim_cfg (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [2:0]                   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    output brim_pkg::t_cfg                    o_cfg
);

    logic [brim_pkg::SIZE_W-1:0] r_buffer_size;
    logic [brim_pkg::SIZE_W-1:0] r_eff_size;
    logic [brim_pkg::SIZE_W-1:0] n_buffer_size;
    logic [brim_pkg::SIZE_W-1:0] n_eff_size;
    logic                        r_clear;
    logic                        wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr == brim_pkg::REG_BUFFER_SIZE);
    assign n_buffer_size = pwdata[brim_pkg::SIZE_W-1:0];

    always_comb begin
        if (n_buffer_size > brim_pkg::SIZE_CAP) begin
            n_eff_size = brim_pkg::SIZE_CAP;
        end else if (n_buffer_size < brim_pkg::SIZE_MIN) begin
            n_eff_size = brim_pkg::SIZE_MIN;
        end else begin
            n_eff_size = n_buffer_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_size <= brim_pkg::SIZE_RESET;
            r_eff_size    <= brim_pkg::SIZE_CAP;
            r_clear       <= 1'b0;
        end else begin
            r_clear <= 1'b0;
            if (wr_hit) begin
                r_buffer_size <= n_buffer_size;
                r_eff_size    <= n_eff_size;
                r_clear       <= 1'b1;
            end
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr == brim_pkg::REG_BUFFER_SIZE) begin
            prdata = {{(32-brim_pkg::SIZE_W){1'b0}}, r_buffer_size};
        end
    end

    assign o_cfg.clear = r_clear;
    assign o_cfg.size  = r_eff_size;

endmodule
`default_nettype wire

### rtl/brim_core.sv
// Index state and the single-pass logic for one request.
`default_nettype none
module brim_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  brim_pkg::t_cfg                     i_cfg,
    input  wire logic                          i_fire,
    input  brim_pkg::t_mode                    i_mode,
    input  wire logic [brim_pkg::SIZE_W-1:0]   i_amount,
    output brim_pkg::t_result                  o_result
);

    localparam int unsigned CW = brim_pkg::CALC_W;

    logic [brim_pkg::IDX_W-1:0]  r_write_index, n_write_index;
    logic [brim_pkg::IDX_W-1:0]  r_read_index, n_read_index;
    logic [brim_pkg::SIZE_W-1:0] r_inv_index, n_inv_index;
    logic                        r_wr_wrap, n_wr_wrap;
    logic                        r_rd_wrap, n_rd_wrap;

    logic [CW-1:0] w, r, inv, sz, amt;
    logic [CW-1:0] freeb, linear, lin_free, base, nxt, ni;

    assign w   = {2'b0, r_write_index};
    assign r   = {2'b0, r_read_index};
    assign inv = {1'b0, r_inv_index};
    assign sz  = {1'b0, i_cfg.size};
    assign amt = {1'b0, i_amount};

    always_comb begin
        n_write_index   = r_write_index;
        n_read_index    = r_read_index;
        n_inv_index     = r_inv_index;
        n_wr_wrap       = r_wr_wrap;
        n_rd_wrap       = r_rd_wrap;
        o_result.status = brim_pkg::STAT_OK;
        o_result.offset = '0;
        o_result.avail  = '0;
        freeb    = (r > w) ? (r - w - 18'd1) : (sz - (w - r) - 18'd1);
        linear   = sz - w;
        lin_free = (freeb < linear) ? freeb : linear;
        base     = '0;
        nxt      = '0;
        ni       = inv;
        case (i_mode)
            brim_pkg::MODE_WR_ACQ: begin
                if (amt <= lin_free) begin
                    o_result.offset = r_write_index;
                end else if (amt <= freeb - lin_free) begin
                    n_wr_wrap = 1'b1;
                end else begin
                    o_result.status = brim_pkg::STAT_NOSPACE;
                end
            end
            brim_pkg::MODE_WR_REL: begin
                base = r_wr_wrap ? '0 : w;
                ni   = r_wr_wrap ? w : inv;
                nxt  = base + amt;
                if (nxt > sz) begin
                    o_result.status = brim_pkg::STAT_TOOBIG;
                end else begin
                    if (nxt > ni) begin
                        ni = nxt;
                    end
                    n_wr_wrap     = 1'b0;
                    n_write_index = (nxt == sz) ? '0 : nxt[brim_pkg::IDX_W-1:0];
                    n_inv_index   = ni[brim_pkg::SIZE_W-1:0];
                end
            end
            brim_pkg::MODE_RD_ACQ: begin
                if (r == w) begin
                    o_result.status = brim_pkg::STAT_NOSPACE;
                end else if (r < w) begin
                    o_result.offset = r_read_index;
                    o_result.avail  = 17'(w - r);
                end else if (inv <= r) begin
                    n_rd_wrap      = 1'b1;
                    o_result.avail = {1'b0, r_write_index};
                end else begin
                    o_result.offset = r_read_index;
                    o_result.avail  = 17'(inv - r);
                end
            end
            brim_pkg::MODE_RD_REL: begin
                base = r_rd_wrap ? '0 : r;
                nxt  = base + amt;
                if (nxt > sz) begin
                    o_result.status = brim_pkg::STAT_TOOBIG;
                end else begin
                    n_rd_wrap    = 1'b0;
                    n_read_index = (nxt == sz) ? '0 : nxt[brim_pkg::IDX_W-1:0];
                end
            end
            default: begin
                o_result.status = brim_pkg::STAT_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg.clear) begin
            r_write_index <= '0;
            r_read_index  <= '0;
            r_inv_index   <= '0;
            r_wr_wrap     <= 1'b0;
            r_rd_wrap     <= 1'b0;
        end else if (i_fire) begin
            r_write_index <= n_write_index;
            r_read_index  <= n_read_index;
            r_inv_index   <= n_inv_index;
            r_wr_wrap     <= n_wr_wrap;
            r_rd_wrap     <= n_rd_wrap;
        end
    end

endmodule
`default_nettype wire

### rtl/bipartite_ring_index_manager.sv
// Top level: request register, index logic, result register and APB port.
// A request waits in the request register; its result is registered when it fires.
// One request per cycle when not stalled; index registers update once per request.
// A stalled result register holds the request register, which then stalls input.
// Reset (synchronous, active low) clears all indices and sets buffer_size to 65536;
// a buffer_size write also clears the indices.
`default_nettype none
module bipartite_ring_index_manager (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [1:0]                    i_mode,
    input  wire logic [brim_pkg::SIZE_W-1:0]   i_amount,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [1:0]                         o_status,
    output logic [brim_pkg::IDX_W-1:0]         o_region_offset,
    output logic [brim_pkg::SIZE_W-1:0]        o_available_count,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready
);

    logic                        r_in_valid;
    brim_pkg::t_mode             r_in_mode;
    logic [brim_pkg::SIZE_W-1:0] r_in_amount;
    logic                        r_out_valid;
    brim_pkg::t_result           r_out;
    brim_pkg::t_result           core_res;
    brim_pkg::t_cfg              cfg;
    logic                        advance;
    logic                        fire;

    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    brim_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    brim_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_fire   (fire),
        .i_mode   (r_in_mode),
        .i_amount (r_in_amount),
        .o_result (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_mode   <= brim_pkg::t_mode'(i_mode);
            r_in_amount <= i_amount;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= core_res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out.status;
    assign o_region_offset   = r_out.offset;
    assign o_available_count = r_out.avail;

endmodule
`default_nettype wire

### bench/tb.sv
// Testbench for the bip-buffer index manager: directed and random requests against a predictor.
`timescale 1ns / 1ps
module tb;

    typedef enum int unsigned {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } t_stall_kind;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_stall;
    logic [1:0]                     i_mode = 2'd0;
    logic [brim_pkg::SIZE_W-1:0]    i_amount = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    logic [1:0]                     o_status;
    logic [brim_pkg::IDX_W-1:0]     o_region_offset;
    logic [brim_pkg::SIZE_W-1:0]    o_available_count;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [2:0]                     paddr = '0;
    logic [31:0]                    pwdata = '0;
    logic [31:0]                    prdata;
    logic                           pready;

    // predicted index state
    logic [brim_pkg::SIZE_W-1:0]    size_reg = brim_pkg::SIZE_RESET;
    logic [brim_pkg::IDX_W-1:0]     wr_idx = '0;
    logic [brim_pkg::IDX_W-1:0]     rd_idx = '0;
    logic [brim_pkg::SIZE_W-1:0]    inv_mark = '0;
    logic                           wr_wrap = 1'b0;
    logic                           rd_wrap = 1'b0;

    brim_pkg::t_result              pending_results[$];
    int unsigned                    mismatches = 0;
    int unsigned                    burst_left = 0;
    t_stall_kind                    stall_kind = STALL_NONE;
    int unsigned                    stall_left = 0;

    bipartite_ring_index_manager u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_mode            (i_mode),
        .i_amount          (i_amount),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_status          (o_status),
        .o_region_offset   (o_region_offset),
        .o_available_count (o_available_count),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always #2 i_clk = ~i_clk;

    function automatic int unsigned eff_size();
        int unsigned sz;
        sz = 32'(size_reg);
        if (sz > 32'(brim_pkg::SIZE_CAP)) sz = 32'(brim_pkg::SIZE_CAP);
        if (sz < 32'(brim_pkg::SIZE_MIN)) sz = 32'(brim_pkg::SIZE_MIN);
        return sz;
    endfunction

    function automatic brim_pkg::t_result predict_request(brim_pkg::t_mode m,
                                                          int unsigned amt);
        int unsigned sz, w, r, inv, fr, lin, lin_fr, base, ni, nw;
        brim_pkg::t_result res;
        sz = eff_size();
        w = 32'(wr_idx);
        r = 32'(rd_idx);
        inv = 32'(inv_mark);
        res.status = brim_pkg::STAT_OK;
        res.offset = '0;
        res.avail = '0;
        case (m)
            brim_pkg::MODE_WR_ACQ: begin
                fr = (r > w) ? r - w - 1 : sz - (w - r) - 1;
                lin = sz - w;
                lin_fr = (fr < lin) ? fr : lin;
                if (amt <= lin_fr) begin
                    res.offset = brim_pkg::IDX_W'(w);
                end else if (amt <= fr - lin_fr) begin
                    wr_wrap = 1'b1;
                end else begin
                    res.status = brim_pkg::STAT_NOSPACE;
                end
            end
            brim_pkg::MODE_WR_REL: begin
                base = wr_wrap ? 0 : w;
                ni = wr_wrap ? w : inv;
                if (base + amt > sz) begin
                    res.status = brim_pkg::STAT_TOOBIG;
                end else begin
                    nw = base + amt;
                    if (nw > ni) ni = nw;
                    if (nw == sz) nw = 0;
                    wr_wrap = 1'b0;
                    wr_idx = brim_pkg::IDX_W'(nw);
                    inv_mark = brim_pkg::SIZE_W'(ni);
                end
            end
            brim_pkg::MODE_RD_ACQ: begin
                if (r == w) begin
                    res.status = brim_pkg::STAT_NOSPACE;
                end else if (r < w) begin
                    res.offset = brim_pkg::IDX_W'(r);
                    res.avail = brim_pkg::SIZE_W'(w - r);
                end else if (inv <= r) begin
                    // mark behind the read index: read wraps to the start
                    rd_wrap = 1'b1;
                    res.avail = brim_pkg::SIZE_W'(w);
                end else begin
                    res.offset = brim_pkg::IDX_W'(r);
                    res.avail = brim_pkg::SIZE_W'(inv - r);
                end
            end
            default: begin
                base = rd_wrap ? 0 : r;
                if (base + amt > sz) begin
                    res.status = brim_pkg::STAT_TOOBIG;
                end else begin
                    nw = base + amt;
                    if (nw == sz) nw = 0;
                    rd_wrap = 1'b0;
                    rd_idx = brim_pkg::IDX_W'(nw);
                end
            end
        endcase
        return res;
    endfunction

    // Receiver stall pattern
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_kind = t_stall_kind'($urandom_range(0, 3));
            stall_left = $urandom_range(20, 200);
        end else begin
            stall_left--;
        end
        case (stall_kind)
            STALL_NONE:  i_out_stall <= 1'b0;
            STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
            default:     i_out_stall <= ~i_out_stall;
        endcase
    end

    always @(posedge i_clk) begin : result_check
        brim_pkg::t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with no request outstanding", $time);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status || o_region_offset !== want.offset ||
                    o_available_count !== want.avail) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display(
                            "%0t: exp st %0d off %0d avail %0d, got st %0d off %0d avail %0d",
                            $time, want.status, want.offset, want.avail,
                            o_status, o_region_offset, o_available_count);
                end
            end
        end
    end

    // Called just after a rising edge; returns just after a rising edge.
    task automatic send_req(input brim_pkg::t_mode m, input int unsigned amt,
                            output brim_pkg::t_result res);
        int unsigned gap;
        i_mode <= m;
        i_amount <= brim_pkg::SIZE_W'(amt);
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        res = predict_request(m, amt);
        pending_results.push_back(res);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid <= 1'b0;
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 10);
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write then read back; the write also clears the indices.
    task automatic write_buffer_size(input logic [31:0] data);
        logic [31:0] readback;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= brim_pkg::REG_BUFFER_SIZE;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        size_reg = data[brim_pkg::SIZE_W-1:0];
        wr_idx = '0;
        rd_idx = '0;
        inv_mark = '0;
        wr_wrap = 1'b0;
        rd_wrap = 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        readback = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (readback[brim_pkg::SIZE_W-1:0] !== data[brim_pkg::SIZE_W-1:0]) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: buffer_size readback exp %0d got %0d", $time,
                         data[brim_pkg::SIZE_W-1:0], readback[brim_pkg::SIZE_W-1:0]);
        end
    endtask

    function automatic logic [31:0] pick_cfg(int unsigned phase);
        logic [31:0] d;
        int unsigned sel;
        d = $urandom();
        sel = (phase == 0) ? 0 : (phase == 1) ? 5 : $urandom_range(0, 7);
        case (sel)
            0: d[brim_pkg::SIZE_W-1:0] = 17'd2;
            1: d[brim_pkg::SIZE_W-1:0] = 17'd3;
            2, 3: d[brim_pkg::SIZE_W-1:0] = brim_pkg::SIZE_W'($urandom_range(4, 32));
            4: d[brim_pkg::SIZE_W-1:0] = brim_pkg::SIZE_W'($urandom_range(33, 2000));
            5: d[brim_pkg::SIZE_W-1:0] = 17'd65536;
            6: d[brim_pkg::SIZE_W-1:0] = brim_pkg::SIZE_W'($urandom_range(0, 131071));
            default: begin
                case ($urandom_range(0, 4))
                    0: d[brim_pkg::SIZE_W-1:0] = 17'd0;
                    1: d[brim_pkg::SIZE_W-1:0] = 17'd1;
                    2: d[brim_pkg::SIZE_W-1:0] = 17'd65535;
                    3: d[brim_pkg::SIZE_W-1:0] = 17'd65537;
                    default: d[brim_pkg::SIZE_W-1:0] = 17'd131071;
                endcase
            end
        endcase
        return d;
    endfunction

    task automatic send_noise(input int unsigned sz);
        brim_pkg::t_result res;
        int unsigned amt;
        case ($urandom_range(0, 6))
            0: amt = 0;
            1: amt = 131071;
            2: amt = $urandom_range(65536, 131071);
            3: amt = sz + 1;
            4: amt = sz;
            default: amt = $urandom_range(0, sz);
        endcase
        send_req(brim_pkg::t_mode'($urandom_range(0, 3)), amt, res);
    endtask

    task automatic test_reset_state();
        brim_pkg::t_result res;
        send_req(brim_pkg::MODE_RD_ACQ, 131071, res);
        send_req(brim_pkg::MODE_WR_ACQ, 0, res);
        send_req(brim_pkg::MODE_WR_ACQ, 65536, res);
        send_req(brim_pkg::MODE_WR_ACQ, 65535, res);
        send_req(brim_pkg::MODE_WR_REL, 131071, res);
        send_req(brim_pkg::MODE_WR_REL, 65535, res);
        send_req(brim_pkg::MODE_RD_ACQ, 0, res);
        send_req(brim_pkg::MODE_RD_REL, 131071, res);
        send_req(brim_pkg::MODE_RD_REL, 65000, res);
        send_req(brim_pkg::MODE_WR_ACQ, 64999, res);
        // too large with a wrap pending: wrap must survive
        send_req(brim_pkg::MODE_WR_REL, 70000, res);
        send_req(brim_pkg::MODE_WR_REL, 64998, res);
        send_req(brim_pkg::MODE_RD_ACQ, 0, res);
        send_req(brim_pkg::MODE_RD_REL, 535, res);
        send_req(brim_pkg::MODE_RD_ACQ, 0, res);
        send_req(brim_pkg::MODE_RD_REL, 64998, res);
    endtask

    task automatic test_size_limits();
        brim_pkg::t_result res;
        wait_idle();
        write_buffer_size(32'hFFFE_0000);
        send_req(brim_pkg::MODE_WR_ACQ, 1, res);
        send_req(brim_pkg::MODE_WR_REL, 1, res);
        send_req(brim_pkg::MODE_WR_ACQ, 1, res);
        send_req(brim_pkg::MODE_RD_ACQ, 0, res);
        send_req(brim_pkg::MODE_RD_REL, 1, res);
        send_req(brim_pkg::MODE_WR_ACQ, 1, res);
        send_req(brim_pkg::MODE_WR_REL, 1, res);
        send_req(brim_pkg::MODE_RD_REL, 2, res);
        wait_idle();
        write_buffer_size(32'h0001_FFFF);
        send_req(brim_pkg::MODE_WR_ACQ, 65535, res);
        wait_idle();
        write_buffer_size(32'd65537);
        send_req(brim_pkg::MODE_WR_ACQ, 65536, res);
    endtask

    task automatic test_unsound_release();
        brim_pkg::t_result res;
        wait_idle();
        write_buffer_size(32'd8);
        send_req(brim_pkg::MODE_WR_ACQ, 6, res);
        send_req(brim_pkg::MODE_WR_REL, 6, res);
        send_req(brim_pkg::MODE_RD_REL, 7, res);
        send_req(brim_pkg::MODE_RD_ACQ, 0, res);
    endtask

    task automatic test_producer_consumer();
        brim_pkg::t_result res;
        int unsigned sz, amt, wr_held, rd_held;
        bit wr_busy, rd_busy;
        for (int unsigned phase = 0; phase < 12; phase++) begin
            // each phase starts from an idle block
            wait_idle();
            write_buffer_size(pick_cfg(phase));
            sz = eff_size();
            wr_busy = 1'b0;
            rd_busy = 1'b0;
            wr_held = 0;
            rd_held = 0;
            repeat ($urandom_range(60, 120)) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_noise(sz);
                end else if ($urandom_range(0, 1) == 0) begin
                    if (!wr_busy) begin
                        case ($urandom_range(0, 7))
                            0: amt = 0;
                            1: amt = sz - 1;
                            2: amt = sz;
                            default: amt = $urandom_range(1, sz / 2);
                        endcase
                        send_req(brim_pkg::MODE_WR_ACQ, amt, res);
                        if (res.status == brim_pkg::STAT_OK) begin
                            wr_busy = 1'b1;
                            wr_held = amt;
                        end
                    end else begin
                        amt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, wr_held)
                                                           : wr_held;
                        send_req(brim_pkg::MODE_WR_REL, amt, res);
                        wr_busy = 1'b0;
                    end
                end else begin
                    if (!rd_busy) begin
                        send_req(brim_pkg::MODE_RD_ACQ, $urandom_range(0, 131071), res);
                        if (res.status == brim_pkg::STAT_OK) begin
                            rd_busy = 1'b1;
                            rd_held = 32'(res.avail);
                        end
                    end else begin
                        amt = ($urandom_range(0, 2) == 0) ? $urandom_range(0, rd_held)
                                                           : rd_held;
                        send_req(brim_pkg::MODE_RD_REL, amt, res);
                        rd_busy = 1'b0;
                    end
                end
            end
        end
    endtask

    task automatic test_noise();
        int unsigned sz;
        for (int unsigned phase = 0; phase < 2; phase++) begin
            wait_idle();
            write_buffer_size(pick_cfg(phase + 2));
            sz = eff_size();
            repeat ($urandom_range(60, 100)) send_noise(sz);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_size_limits();
        test_unsound_release();
        test_producer_consumer();
        test_noise();
        wait_idle();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule

### bipartite_ring_index_manager.f
rtl/brim_pkg.sv
rtl/brim_cfg.sv
rtl/brim_core.sv
rtl/bipartite_ring_index_manager.sv
bench/tb.sv
